// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dcal_pkg.sv =====
// ----------------------------------------------------------------------------
// dcal_pkg
// shared types, constants and month length lookup for the date counter
// ----------------------------------------------------------------------------
`default_nettype none

package dcal_pkg;

  localparam logic [13:0] MIN_YEAR   = 14'd1900;
  localparam logic [13:0] MAX_YEAR   = 14'd9999;
  localparam logic [13:0] RESET_YEAR = 14'd1900;
  // 1900 = 19 * 100 + 0, 19 mod 4 = 3
  localparam logic [6:0]  RESET_YMOD = 7'd0;
  localparam logic [1:0]  RESET_CENT = 2'd3;
  localparam logic [6:0]  YMOD_TOP   = 7'd99;
  localparam logic [3:0]  LAST_MONTH = 4'd12;
  localparam logic [4:0]  LAST_DAY   = 5'd31;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BADLOAD = 2'd2
  } status_t;

  // buffered input word with the load year split by 100
  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  ymod;
    logic [1:0]  cent;
  } item_t;

  // held date, with year mod 100 and century mod 4 for the leap rule
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  ymod;
    logic [1:0]  cent;
  } date_t;

  function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] ymod,
                                   input logic [1:0] cent);
    return (y_lo == 2'd0) && ((ymod != 7'd0) || (cent == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        len = 5'd31;
      end
      default: begin
        len = 5'd0;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dcal_in.sv =====
// ----------------------------------------------------------------------------
// dcal_in
// input word register; splits the load year into mod 100 and century mod 4
// ----------------------------------------------------------------------------
`default_nettype none

module dcal_in
  import dcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [13:0] in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  input  wire logic        adv,
  output logic             item_valid,
  output item_t            item
);

  logic        valid_r;
  logic        valid_nxt;
  item_t       item_r;
  item_t       item_nxt;
  logic [26:0] prod;
  logic [7:0]  quot;
  logic [13:0] quot100;
  logic [13:0] rem;
  logic        take;

  // year / 100 by reciprocal, exact below 16384
  assign prod    = {13'd0, in_load_year} * 27'd5243;
  assign quot    = prod[26:19];
  assign quot100 = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'd0};
  assign rem     = in_load_year - quot100;

  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
    item_nxt.op    = in_operation;
    item_nxt.year  = in_load_year;
    item_nxt.month = in_load_month;
    item_nxt.day   = in_load_day;
    item_nxt.ymod  = rem[6:0];
    item_nxt.cent  = quot[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dcal_step.sv =====
// ----------------------------------------------------------------------------
// dcal_step
// next date for one word: load with checks, advance or step back one day
// ----------------------------------------------------------------------------
`default_nettype none

module dcal_step
  import dcal_pkg::*;
(
  input  wire item_t    item,
  input  wire date_t    cur,
  output date_t         nxt,
  output logic          nxt_leap,
  output status_t       status
);

  logic       leap_cur;
  logic       leap_ld;
  logic [4:0] len_cur;
  logic [4:0] len_ld;
  logic [4:0] len_prev;
  logic [3:0] month_dec;
  logic       load_ok;

  assign leap_cur  = is_leap(cur.year[1:0], cur.ymod, cur.cent);
  assign leap_ld   = is_leap(item.year[1:0], item.ymod, item.cent);
  assign len_cur   = month_len(cur.month, leap_cur);
  assign len_ld    = month_len(item.month, leap_ld);
  assign month_dec = cur.month - 4'd1;
  assign len_prev  = month_len(month_dec, leap_cur);

  assign load_ok = (item.year >= MIN_YEAR) && (item.year <= MAX_YEAR) &&
                   (item.month >= 4'd1) && (item.month <= LAST_MONTH) &&
                   (item.day >= 5'd1) && (item.day <= len_ld);

  always_comb begin
    nxt    = cur;
    status = ST_OK;
    case (op_t'(item.op))
      OP_LOAD: begin
        if (load_ok) begin
          nxt.year  = item.year;
          nxt.month = item.month;
          nxt.day   = item.day;
          nxt.ymod  = item.ymod;
          nxt.cent  = item.cent;
        end else begin
          status = ST_BADLOAD;
        end
      end
      OP_NEXT: begin
        if (cur.day < len_cur) begin
          nxt.day = cur.day + 5'd1;
        end else if (cur.month < LAST_MONTH) begin
          nxt.month = cur.month + 4'd1;
          nxt.day   = 5'd1;
        end else if (cur.year < MAX_YEAR) begin
          nxt.year  = cur.year + 14'd1;
          nxt.month = 4'd1;
          nxt.day   = 5'd1;
          if (cur.ymod == YMOD_TOP) begin
            nxt.ymod = 7'd0;
            nxt.cent = cur.cent + 2'd1;
          end else begin
            nxt.ymod = cur.ymod + 7'd1;
          end
        end else begin
          status = ST_RANGE;
        end
      end
      OP_PREV: begin
        if (cur.day > 5'd1) begin
          nxt.day = cur.day - 5'd1;
        end else if (cur.month > 4'd1) begin
          nxt.month = month_dec;
          nxt.day   = len_prev;
        end else if (cur.year > MIN_YEAR) begin
          nxt.year  = cur.year - 14'd1;
          nxt.month = LAST_MONTH;
          nxt.day   = LAST_DAY;
          if (cur.ymod == 7'd0) begin
            nxt.ymod = YMOD_TOP;
            nxt.cent = cur.cent - 2'd1;
          end else begin
            nxt.ymod = cur.ymod - 7'd1;
          end
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign nxt_leap = is_leap(nxt.year[1:0], nxt.ymod, nxt.cent);

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_up_down_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_date_up_down_counter
// gregorian date counter: load, advance or step back one day per word
// path: accepted word goes to the dcal_in input register, then the date and
// result registers; throughput: one word per cycle when out_stall is low,
// set by the single date update stage
// reset: synchronous, date returns to 1900-01-01, no words in flight
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module calendar_date_up_down_counter
  import dcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [13:0] in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [13:0]      out_cur_year,
  output logic [3:0]       out_cur_month,
  output logic [4:0]       out_cur_day,
  output logic             out_leap,
  output logic [1:0]       out_status
);

  logic    adv;
  logic    item_valid;
  item_t   item;
  logic    step;
  date_t   date_r;
  date_t   date_nxt;
  logic    leap_nxt;
  status_t status_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  date_t   out_date_r;
  logic    out_leap_r;
  status_t out_status_r;
  logic    date_ok;
  logic    out_same;

  assign adv  = !out_valid_r || !out_stall;
  assign step = item_valid && adv;

  dcal_in u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_load_year  (in_load_year),
    .in_load_month (in_load_month),
    .in_load_day   (in_load_day),
    .adv           (adv),
    .item_valid    (item_valid),
    .item          (item)
  );

  dcal_step u_step (
    .item     (item),
    .cur      (date_r),
    .nxt      (date_nxt),
    .nxt_leap (leap_nxt),
    .status   (status_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r.year  <= RESET_YEAR;
      date_r.month <= 4'd1;
      date_r.day   <= 5'd1;
      date_r.ymod  <= RESET_YMOD;
      date_r.cent  <= RESET_CENT;
      out_valid_r  <= 1'b0;
    end else begin
      if (step) begin
        date_r <= date_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_date_r   <= date_nxt;
      out_leap_r   <= leap_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cur_year  = out_date_r.year;
  assign out_cur_month = out_date_r.month;
  assign out_cur_day   = out_date_r.day;
  assign out_leap      = out_leap_r;
  assign out_status    = out_status_r;

  assign date_ok  = (date_r.month >= 4'd1) && (date_r.month <= LAST_MONTH) &&
                    (date_r.day >= 5'd1) && (date_r.year >= MIN_YEAR) &&
                    (date_r.year <= MAX_YEAR) && (date_r.ymod <= YMOD_TOP);
  assign out_same = (out_date_r.year == date_r.year) &&
                    (out_date_r.month == date_r.month) &&
                    (out_date_r.day == date_r.day);

  `ASSERT_NEXT(a_date_hold, clk, rst_n, !step, $stable(date_r), "date changed without a word")
  `ASSERT_ALWAYS(a_date_range, clk, rst_n, date_ok, "held date out of range")
  `ASSERT_IMPL(a_out_match, clk, rst_n, out_valid_r, out_same, "result word differs from date")
  `ASSERT_IMPL(a_range_keep, clk, rst_n, step && (status_nxt != ST_OK), date_nxt == date_r, "refused word changed the date")

endmodule

`default_nettype wire
